// ===== src/eulzxy_pkg.sv =====
package eulzxy_pkg;

  localparam int N_CORDIC_STEPS = 18;
  localparam int SQRT_STEPS     = 31;

  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [19:0] TWO_PI_Q16  = 20'sd411775;
  localparam logic signed [19:0] PI_Q16      = 20'sd205887;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [17:0] HALF_PI_18  = 18'sd102944;
  localparam logic signed [17:0] ONE_Q16     = 18'sd65536;

  typedef logic signed [33:0] q30_t;
  typedef logic signed [17:0] q16_t;

  // Arctangent of 2^-i in Q30, truncated.
  function automatic q30_t atan_at(input int i);
    q30_t v;
    case (i)
      0:  v = 34'sd843314856;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043836;
      3:  v = 34'sd133525158;
      4:  v = 34'sd67021686;
      5:  v = 34'sd33543515;
      6:  v = 34'sd16775850;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194282;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      23: v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Rounds a Q30 value to Q16 and clamps it to +-lim.
  function automatic q16_t q30_q16(input q30_t v, input q16_t lim);
    q30_t t;
    q30_t l;
    t = (v + 34'sd8192) >>> 14;
    l = 34'(lim);
    if (t > l) t = l;
    else if (t < -l) t = -l;
    return t[17:0];
  endfunction

  // Q16 product, rounded half up.
  function automatic q16_t qmul(input q16_t a, input q16_t b);
    logic signed [35:0] p;
    p = (a * b + 36'sd32768) >>> 16;
    return p[17:0];
  endfunction

  function automatic q16_t clamp_one(input logic signed [18:0] v);
    q16_t r;
    if (v > 19'sd65536) r = ONE_Q16;
    else if (v < -19'sd65536) r = -ONE_Q16;
    else r = v[17:0];
    return r;
  endfunction

endpackage

// ===== src/eulzxy_rot_cell.sv =====
module eulzxy_rot_cell
  import eulzxy_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic en,
  input  q30_t x_i,
  input  q30_t y_i,
  input  q30_t z_i,
  output q30_t x_o,
  output q30_t y_o,
  output q30_t z_o
);

  q30_t dx;
  q30_t dy;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_i >= 0) begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - atan_at(STEP);
      end else begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + atan_at(STEP);
      end
    end
  end

endmodule

// ===== src/eulzxy_vec_cell.sv =====
module eulzxy_vec_cell
  import eulzxy_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic en,
  input  q30_t x_i,
  input  q30_t y_i,
  input  q30_t z_i,
  output q30_t x_o,
  output q30_t y_o,
  output q30_t z_o
);

  q30_t dx;
  q30_t dy;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (y_i >= 0) begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + atan_at(STEP);
      end else begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - atan_at(STEP);
      end
    end
  end

endmodule

// ===== src/eulzxy_sqrt_cell.sv =====
module eulzxy_sqrt_cell
  import eulzxy_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [61:0] v_i,
  input  logic [61:0] res_i,
  output logic [61:0] v_o,
  output logic [61:0] res_o
);

  localparam logic [61:0] BIT = 62'(1) << (60 - 2 * STEP);

  logic [61:0] trial;

  assign trial = res_i + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (v_i >= trial) begin
        v_o   <= v_i - trial;
        res_o <= (res_i >> 1) + BIT;
      end else begin
        v_o   <= v_i;
        res_o <= res_i >> 1;
      end
    end
  end

endmodule

// ===== src/euler_zxy_rotation_matrix.sv =====
// Z-X-Y Euler rotation matrix with angle recovery, fully pipelined.
// Throughput: one transfer per cycle; the whole pipeline holds while a result waits.
// Latency comes from the angle reduction, rotation CORDIC row, sine/cosine, product and
// recovery setup registers, the 31-cell square-root row, the vectoring CORDIC row and the
// output register. Synchronous active-low reset clears only the valid bits.
module euler_zxy_rotation_matrix
  import eulzxy_pkg::*;
#(
  parameter int CORDIC_STEPS = N_CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_alpha,
  input  logic signed [23:0] in_beta,
  input  logic signed [23:0] in_gamma,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] out_row0_col0,
  output logic signed [17:0] out_row0_col1,
  output logic signed [17:0] out_row0_col2,
  output logic signed [17:0] out_row1_col0,
  output logic signed [17:0] out_row1_col1,
  output logic signed [17:0] out_row1_col2,
  output logic signed [17:0] out_row2_col0,
  output logic signed [17:0] out_row2_col1,
  output logic signed [17:0] out_row2_col2,
  output logic signed [17:0] out_alpha_recovered,
  output logic signed [17:0] out_beta_recovered,
  output logic signed [17:0] out_gamma_recovered
);

  localparam int LAT = 39 + 2 * CORDIC_STEPS;

  typedef struct packed {
    logic [8:0][17:0] m;
    logic [2:0]       ovr;
    logic [2:0][17:0] ovv;
    q30_t             xa;
    q30_t             ya;
    q30_t             xg;
    q30_t             yg;
    q30_t             ys;
  } carry_t;

  logic en;
  logic [LAT-1:0] vld_r;

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Angle reduction: floor modulo 2*pi by reciprocal multiply, then a fold to +-pi/2.
  logic signed [23:0] ang [3];
  logic [24:0] u_r [3];
  logic [5:0]  qe_r [3];
  q30_t        z0_r [3];
  logic        cneg0_r [3];

  assign ang[0] = in_alpha;
  assign ang[1] = in_beta;
  assign ang[2] = in_gamma;

  always_ff @(posedge clk) begin
    logic signed [25:0] ut;
    logic [38:0]        prod;
    logic [24:0]        r0;
    logic signed [19:0] rs;
    logic               cn;
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        ut = 26'(ang[l]) + 26'sd8647275;
        prod = 39'(ut[24:0]) * 39'd10430;
        u_r[l]  <= ut[24:0];
        qe_r[l] <= prod[37:32];

        r0 = u_r[l] - 25'(qe_r[l] * 25'd411775);
        if (r0 >= 25'd411775) r0 = r0 - 25'd411775;
        rs = 20'(r0);
        if (rs > PI_Q16) rs = rs - TWO_PI_Q16;
        cn = 1'b0;
        if (rs > HALF_PI_Q16) begin
          rs = PI_Q16 - rs;
          cn = 1'b1;
        end else if (rs < -HALF_PI_Q16) begin
          rs = -PI_Q16 - rs;
          cn = 1'b1;
        end
        cneg0_r[l] <= cn;
        z0_r[l] <= 34'(rs) <<< 14;
      end
    end
  end

  // Rotation CORDIC rows, one lane per angle.
  q30_t rx [3][CORDIC_STEPS+1];
  q30_t ry [3][CORDIC_STEPS+1];
  q30_t rz [3][CORDIC_STEPS+1];
  logic [CORDIC_STEPS-1:0] cneg_r [3];

  for (genvar l = 0; l < 3; l++) begin : g_rot
    assign rx[l][0] = GAIN_Q30;
    assign ry[l][0] = '0;
    assign rz[l][0] = z0_r[l];
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      eulzxy_rot_cell #(.STEP(i)) u_cell (
        .clk (clk),
        .en  (en),
        .x_i (rx[l][i]),
        .y_i (ry[l][i]),
        .z_i (rz[l][i]),
        .x_o (rx[l][i+1]),
        .y_o (ry[l][i+1]),
        .z_o (rz[l][i+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        cneg_r[l] <= {cneg_r[l][CORDIC_STEPS-2:0], cneg0_r[l]};
      end
    end
  end

  // Sine and cosine in Q16.
  q16_t sin_r [3];
  q16_t cos_r [3];

  always_ff @(posedge clk) begin
    q16_t c;
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        sin_r[l] <= q30_q16(ry[l][CORDIC_STEPS], ONE_Q16);
        c = q30_q16(rx[l][CORDIC_STEPS], ONE_Q16);
        cos_r[l] <= cneg_r[l][CORDIC_STEPS-1] ? -c : c;
      end
    end
  end

  // Products: pairs, then triples, then sums.
  q16_t p_cacy_r, p_sasb_r, p_cysa_r, p_casb_r, p_sasy_r;
  q16_t p_cbsa_r, p_cacb_r, p_cbsy_r, p_cbcy_r, p_casy_r;
  q16_t sb1_r, sy1_r;
  q16_t t0_r, t2_r, t3_r, t5_r, sb2_r;
  q16_t c_cacy_r, c_casy_r, c_cysa_r, c_sasy_r, c_cbsa_r, c_cacb_r, c_cbsy_r, c_cbcy_r;
  q16_t m_r [9];

  always_ff @(posedge clk) begin
    if (en) begin
      p_cacy_r <= qmul(cos_r[0], cos_r[2]);
      p_sasb_r <= qmul(sin_r[0], sin_r[1]);
      p_cysa_r <= qmul(cos_r[2], sin_r[0]);
      p_casb_r <= qmul(cos_r[0], sin_r[1]);
      p_sasy_r <= qmul(sin_r[0], sin_r[2]);
      p_cbsa_r <= qmul(cos_r[1], sin_r[0]);
      p_cacb_r <= qmul(cos_r[0], cos_r[1]);
      p_cbsy_r <= qmul(cos_r[1], sin_r[2]);
      p_cbcy_r <= qmul(cos_r[1], cos_r[2]);
      p_casy_r <= qmul(cos_r[0], sin_r[2]);
      sb1_r    <= sin_r[1];
      sy1_r    <= sin_r[2];

      t0_r     <= qmul(p_sasb_r, sy1_r);
      t2_r     <= qmul(p_cysa_r, sb1_r);
      t3_r     <= qmul(p_casb_r, sy1_r);
      t5_r     <= qmul(p_cacy_r, sb1_r);
      sb2_r    <= sb1_r;
      c_cacy_r <= p_cacy_r;
      c_casy_r <= p_casy_r;
      c_cysa_r <= p_cysa_r;
      c_sasy_r <= p_sasy_r;
      c_cbsa_r <= p_cbsa_r;
      c_cacb_r <= p_cacb_r;
      c_cbsy_r <= p_cbsy_r;
      c_cbcy_r <= p_cbcy_r;

      m_r[0] <= clamp_one(19'(c_cacy_r) - 19'(t0_r));
      m_r[1] <= clamp_one(-19'(c_cbsa_r));
      m_r[2] <= clamp_one(19'(c_casy_r) + 19'(t2_r));
      m_r[3] <= clamp_one(19'(c_cysa_r) + 19'(t3_r));
      m_r[4] <= clamp_one(19'(c_cacb_r));
      m_r[5] <= clamp_one(19'(c_sasy_r) - 19'(t5_r));
      m_r[6] <= clamp_one(-19'(c_cbsy_r));
      m_r[7] <= clamp_one(19'(sb2_r));
      m_r[8] <= clamp_one(19'(c_cbcy_r));
    end
  end

  // Recovery setup: quotient signs, zero denominators, and the asin radicand.
  carry_t      prep_r;
  logic [61:0] v0_r;

  always_ff @(posedge clk) begin
    logic signed [18:0] n;
    logic signed [18:0] d;
    logic signed [35:0] ss;
    if (en) begin
      for (int j = 0; j < 9; j++) prep_r.m[j] <= m_r[j];

      n = -19'(m_r[1]);
      d = 19'(m_r[4]);
      prep_r.ovr[0] <= (d == 0);
      prep_r.ovv[0] <= (n > 0) ? HALF_PI_18 : ((n < 0) ? -HALF_PI_18 : 18'sd0);
      if (d < 0) begin
        prep_r.xa <= -(34'(d) <<< 14);
        prep_r.ya <= -(34'(n) <<< 14);
      end else begin
        prep_r.xa <= 34'(d) <<< 14;
        prep_r.ya <= 34'(n) <<< 14;
      end

      n = -19'(m_r[6]);
      d = 19'(m_r[8]);
      prep_r.ovr[2] <= (d == 0);
      prep_r.ovv[2] <= (n > 0) ? HALF_PI_18 : ((n < 0) ? -HALF_PI_18 : 18'sd0);
      if (d < 0) begin
        prep_r.xg <= -(34'(d) <<< 14);
        prep_r.yg <= -(34'(n) <<< 14);
      end else begin
        prep_r.xg <= 34'(d) <<< 14;
        prep_r.yg <= 34'(n) <<< 14;
      end

      prep_r.ovr[1] <= (m_r[7] >= ONE_Q16) || (m_r[7] <= -ONE_Q16);
      prep_r.ovv[1] <= (m_r[7] >= ONE_Q16) ? HALF_PI_18 : -HALF_PI_18;
      prep_r.ys     <= 34'(m_r[7]) <<< 14;
      ss = m_r[7] * m_r[7];
      v0_r <= 62'((34'h1_0000_0000 - 34'(ss)) << 28);
    end
  end

  // Integer square root row for asin.
  logic [61:0] sv [SQRT_STEPS+1];
  logic [61:0] sr [SQRT_STEPS+1];
  carry_t      sq_c_r [SQRT_STEPS];

  assign sv[0] = v0_r;
  assign sr[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    eulzxy_sqrt_cell #(.STEP(k)) u_cell (
      .clk   (clk),
      .en    (en),
      .v_i   (sv[k]),
      .res_i (sr[k]),
      .v_o   (sv[k+1]),
      .res_o (sr[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_c_r[0] <= prep_r;
      for (int k = 1; k < SQRT_STEPS; k++) sq_c_r[k] <= sq_c_r[k-1];
    end
  end

  // Vectoring CORDIC rows.
  q30_t vx [3][CORDIC_STEPS+1];
  q30_t vy [3][CORDIC_STEPS+1];
  q30_t vz [3][CORDIC_STEPS+1];
  carry_t vc_r [CORDIC_STEPS];
  carry_t sq_last;

  assign sq_last  = sq_c_r[SQRT_STEPS-1];
  assign vx[0][0] = sq_last.xa;
  assign vy[0][0] = sq_last.ya;
  assign vx[1][0] = sr[SQRT_STEPS][33:0];
  assign vy[1][0] = sq_last.ys;
  assign vx[2][0] = sq_last.xg;
  assign vy[2][0] = sq_last.yg;

  for (genvar l = 0; l < 3; l++) begin : g_vec
    assign vz[l][0] = '0;
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      eulzxy_vec_cell #(.STEP(i)) u_cell (
        .clk (clk),
        .en  (en),
        .x_i (vx[l][i]),
        .y_i (vy[l][i]),
        .z_i (vz[l][i]),
        .x_o (vx[l][i+1]),
        .y_o (vy[l][i+1]),
        .z_o (vz[l][i+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vc_r[0] <= sq_last;
      for (int i = 1; i < CORDIC_STEPS; i++) vc_r[i] <= vc_r[i-1];
    end
  end

  // Output register.
  carry_t vc_last;
  q16_t   ang_r [3];
  q16_t   mo_r [9];

  assign vc_last = vc_r[CORDIC_STEPS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 9; j++) mo_r[j] <= vc_last.m[j];
      for (int l = 0; l < 3; l++) begin
        ang_r[l] <= vc_last.ovr[l] ? q16_t'(vc_last.ovv[l])
                                   : q30_q16(vz[l][CORDIC_STEPS], HALF_PI_18);
      end
    end
  end

  assign out_row0_col0       = mo_r[0];
  assign out_row0_col1       = mo_r[1];
  assign out_row0_col2       = mo_r[2];
  assign out_row1_col0       = mo_r[3];
  assign out_row1_col1       = mo_r[4];
  assign out_row1_col2       = mo_r[5];
  assign out_row2_col0       = mo_r[6];
  assign out_row2_col1       = mo_r[7];
  assign out_row2_col2       = mo_r[8];
  assign out_alpha_recovered = ang_r[0];
  assign out_beta_recovered  = ang_r[1];
  assign out_gamma_recovered = ang_r[2];

endmodule
